// ===== rtl/core/mdio_management_master_macros.svh =====
// Assertion macros shared by the management master checkers.
// Depends on nothing; included by the checker file.
`ifndef MDIO_MANAGEMENT_MASTER_MACROS_SVH
`define MDIO_MANAGEMENT_MASTER_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define MDIO_MM_ASSERT_NOW(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("management master check failed: same-cycle rule");

// Check that a condition implies another in the next cycle.
`define MDIO_MM_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("management master check failed: next-cycle rule");

`endif

// ===== rtl/core/mdio_mm_pkg.sv =====
// Types and constants of the MDIO management master.
// Used by the channel interfaces, the top level and the checker.
package mdio_mm_pkg;

  localparam int unsigned FRAME_BITS    = 33;
  localparam int unsigned PREAMBLE_MAX  = 32;
  localparam int unsigned POS_W         = 7;
  localparam int unsigned DIV_W         = 8;
  localparam int unsigned PRE_W         = 6;
  localparam int unsigned DATA_W        = 16;
  localparam int unsigned ADDR_W        = 5;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 8;

  localparam logic [DIV_W-1:0] HALF_TICKS_RESET = 8'd7;
  localparam logic [PRE_W-1:0] PREAMBLE_RESET   = 6'd32;

  // Last bit position that carries read data, first one too.
  localparam logic [POS_W-1:0] RD_POS_LO = 7'd2;
  localparam logic [POS_W-1:0] RD_POS_HI = 7'd17;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_SPARE = 2'd3
  } req_type_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MDC_HALF_TICKS = 2'd0,
    CFG_PREAMBLE_BITS  = 2'd1
  } cfg_index_t;

  localparam logic [1:0] START_BITS = 2'b01;
  localparam logic [1:0] OP_READ    = 2'b10;
  localparam logic [1:0] OP_WRITE   = 2'b01;
  localparam logic [1:0] TA_READ    = 2'b11;
  localparam logic [1:0] TA_WRITE   = 2'b10;

endpackage

// ===== rtl/core/mdio_mm_req_if.sv =====
// Request and tick channel of the MDIO management master.
// Depends on mdio_mm_pkg.
interface mdio_mm_req_if;
  import mdio_mm_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [ADDR_W-1:0] phy_addr;
  logic [ADDR_W-1:0] reg_addr;
  logic [DATA_W-1:0] write_data;
  logic              mdio_in;

  modport source (output valid, req_type, phy_addr, reg_addr, write_data, mdio_in,
                  input ready);
  modport sink   (input valid, req_type, phy_addr, reg_addr, write_data, mdio_in,
                  output ready);
endinterface

// ===== rtl/core/mdio_mm_res_if.sv =====
// Result channel of the MDIO management master.
// Depends on mdio_mm_pkg.
interface mdio_mm_res_if;
  import mdio_mm_pkg::*;

  logic              valid;
  logic              ready;
  logic              mdc;
  logic              mdio_level;
  logic              mdio_drive;
  logic              busy_res;
  logic              done_res;
  logic [DATA_W-1:0] read_data;
  logic              request_ignored;

  modport source (output valid, mdc, mdio_level, mdio_drive, busy_res, done_res, read_data,
                  request_ignored, input ready);
  modport sink   (input valid, mdc, mdio_level, mdio_drive, busy_res, done_res, read_data,
                  request_ignored, output ready);
endinterface

// ===== rtl/core/mdio_mm_cfg_if.sv =====
// Configuration write channel of the MDIO management master.
// Depends on mdio_mm_pkg.
interface mdio_mm_cfg_if;
  import mdio_mm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/mdio_management_master.sv =====
// Channel   Dir  Payload
// req       in   req_type, phy_addr, reg_addr, write_data, mdio_in
// res       out  mdc, mdio_level, mdio_drive, busy_res, done_res, read_data, request_ignored
// cfg       in   index (0 mdc_half_ticks, 1 preamble_bits), data
//
// One item is accepted per clock while the result is taken; its result is registered and shows in the next cycle.
// The frame state and the result register update together in one pass of logic.
// A result not taken holds the result register and lowers req.ready until it leaves.
// Synchronous reset clears the frame state and the result valid; registers return
// to 7 half-period ticks and 32 preamble bits. Configuration writes are always taken.
// Depends on mdio_mm_pkg and the three channel interfaces.
module mdio_management_master (
  input  logic                   clk,
  input  logic                   rst,
  mdio_mm_req_if.sink            req,
  mdio_mm_res_if.source          res,
  mdio_mm_cfg_if.sink            cfg
);
  import mdio_mm_pkg::*;

  // Configuration registers
  logic [DIV_W-1:0]      mdc_half_ticks;
  logic [PRE_W-1:0]      preamble_bits;

  // Frame state
  logic                  active, active_next;
  logic [POS_W-1:0]      bit_position, bit_position_next;
  logic [DIV_W-1:0]      divider_count, divider_count_next;
  logic                  clock_level, clock_level_next;
  logic                  read_op, read_op_next;
  logic [FRAME_BITS-1:0] send_shift, send_shift_next;
  logic [DATA_W-1:0]     capture_shift, capture_shift_next;
  logic [DATA_W-1:0]     last_read, last_read_next;

  // Step results
  logic                  done_next;
  logic                  ignored_next;
  logic                  rd_now;
  logic                  rd_next;
  logic                  bit_next;
  logic [DIV_W-1:0]      half;
  logic [DIV_W-1:0]      div_inc;
  logic [PRE_W-1:0]      pre_sat;
  logic [5:0]            bit_idx;
  logic                  accept;

  assign cfg.ready = 1'b1;
  assign req.ready = !res.valid || res.ready;
  assign accept    = req.valid && req.ready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mdc_half_ticks <= HALF_TICKS_RESET;
      preamble_bits  <= PREAMBLE_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_MDC_HALF_TICKS: mdc_half_ticks <= cfg.data;
        CFG_PREAMBLE_BITS:  preamble_bits  <= cfg.data[PRE_W-1:0];
        default: ;
      endcase
    end
  end

  assign half    = (mdc_half_ticks == '0) ? DIV_W'(1) : mdc_half_ticks;
  assign div_inc = divider_count + DIV_W'(1);
  assign pre_sat = (preamble_bits > PRE_W'(PREAMBLE_MAX)) ? PRE_W'(PREAMBLE_MAX)
                                                          : preamble_bits;
  assign rd_now  = active && read_op && (bit_position >= RD_POS_LO)
                   && (bit_position <= RD_POS_HI);

  // Advance the frame by one item
  always_comb begin
    active_next        = active;
    bit_position_next  = bit_position;
    divider_count_next = divider_count;
    clock_level_next   = clock_level;
    read_op_next       = read_op;
    send_shift_next    = send_shift;
    capture_shift_next = capture_shift;
    last_read_next     = last_read;
    done_next          = 1'b0;
    ignored_next       = 1'b0;
    case (req.req_type) inside
      REQ_READ, REQ_WRITE: begin
        if (active) begin
          ignored_next = 1'b1;
        end else begin
          read_op_next = (req.req_type == REQ_READ);
          if (req.req_type == REQ_READ) begin
            send_shift_next = {START_BITS, OP_READ, req.phy_addr, req.reg_addr, TA_READ,
                               {DATA_W{1'b0}}, 1'b0};
          end else begin
            send_shift_next = {START_BITS, OP_WRITE, req.phy_addr, req.reg_addr, TA_WRITE,
                               req.write_data, 1'b0};
          end
          bit_position_next  = POS_W'(pre_sat) + POS_W'(FRAME_BITS);
          active_next        = 1'b1;
          clock_level_next   = 1'b1;
          divider_count_next = '0;
          capture_shift_next = '0;
        end
      end
      default: begin
        if (active) begin
          divider_count_next = div_inc;
          if (div_inc >= half) begin
            divider_count_next = '0;
            if (clock_level) begin
              if (rd_now) begin
                capture_shift_next = {capture_shift[DATA_W-2:0], req.mdio_in};
              end
              clock_level_next = 1'b0;
            end else begin
              bit_position_next = bit_position - POS_W'(1);
              if (bit_position == POS_W'(1)) begin
                active_next = 1'b0;
                done_next   = 1'b1;
                if (read_op) begin
                  last_read_next = capture_shift;
                end
              end else begin
                clock_level_next = 1'b1;
              end
            end
          end
        end
      end
    endcase
  end

  // Pin levels from the updated state
  assign rd_next = active_next && read_op_next && (bit_position_next >= RD_POS_LO)
                   && (bit_position_next <= RD_POS_HI);
  assign bit_idx = 6'(bit_position_next - POS_W'(1));

  always_comb begin
    if (!active_next || bit_position_next == '0) begin
      bit_next = 1'b0;
    end else if (bit_position_next > POS_W'(FRAME_BITS)) begin
      bit_next = 1'b1;
    end else begin
      bit_next = send_shift_next[bit_idx];
    end
  end

  // Update frame state on accepted items
  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      bit_position  <= '0;
      divider_count <= '0;
      clock_level   <= 1'b0;
      read_op       <= 1'b0;
      send_shift    <= '0;
      capture_shift <= '0;
      last_read     <= '0;
    end else if (accept) begin
      active        <= active_next;
      bit_position  <= bit_position_next;
      divider_count <= divider_count_next;
      clock_level   <= clock_level_next;
      read_op       <= read_op_next;
      send_shift    <= send_shift_next;
      capture_shift <= capture_shift_next;
      last_read     <= last_read_next;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (accept) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res.mdc             <= active_next && clock_level_next;
      res.mdio_level      <= rd_next ? 1'b0 : bit_next;
      res.mdio_drive      <= active_next && !rd_next;
      res.busy_res        <= active_next;
      res.done_res        <= done_next;
      res.read_data       <= last_read_next;
      res.request_ignored <= ignored_next;
    end
  end

endmodule

// ===== rtl/core/mdio_mm_checker.sv =====
// Port-level checks of the MDIO management master, bound to the top level.
// Depends on mdio_mm_pkg and mdio_management_master_macros.svh.
`include "mdio_management_master_macros.svh"

module mdio_mm_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           res_valid,
  input logic                           res_ready,
  input logic                           mdc,
  input logic                           mdio_level,
  input logic                           mdio_drive,
  input logic                           busy_res,
  input logic                           done_res,
  input logic [mdio_mm_pkg::DATA_W-1:0] read_data
);
  import mdio_mm_pkg::*;

  logic [DATA_W+4:0] res_payload;

  assign res_payload = {mdc, mdio_level, mdio_drive, busy_res, done_res, read_data};

  // A stalled result keeps its payload
  `MDIO_MM_ASSERT_NEXT(res_hold_a, clk, rst, res_valid && !res_ready, res_valid && $stable(res_payload))
  // A finished frame leaves the block idle
  `MDIO_MM_ASSERT_NOW(done_idle_a, clk, rst, res_valid && done_res, !busy_res)
  // An idle block parks the pins
  `MDIO_MM_ASSERT_NOW(idle_pins_a, clk, rst, res_valid && !busy_res, !mdc && !mdio_drive && !mdio_level)
  // A released line shows a low level
  `MDIO_MM_ASSERT_NOW(release_low_a, clk, rst, res_valid && !mdio_drive, !mdio_level)

endmodule

bind mdio_management_master mdio_mm_checker u_mdio_mm_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .mdc        (res.mdc),
  .mdio_level (res.mdio_level),
  .mdio_drive (res.mdio_drive),
  .busy_res   (res.busy_res),
  .done_res   (res.done_res),
  .read_data  (res.read_data)
);
